[rtl/core/msp_pkg.sv]
// Package for the matrix saddle point search block.
// Holds the fixed field widths, register indexes, count reset values and the shared update struct.
// No dependencies.
package msp_pkg;

   // Fixed field widths.
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int COUNT_WIDTH     = 4;
   localparam int INDEX_WIDTH     = 3;

   // Register indexes on the configuration channel.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROW_COUNT = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COL_COUNT = 4'd1;

   // Reset values of the count registers.
   localparam logic [COUNT_WIDTH-1:0] ROW_COUNT_RESET = 4'd8;
   localparam logic [COUNT_WIDTH-1:0] COL_COUNT_RESET = 4'd8;

   // Control of the row maximum / column minimum update.
   typedef struct packed {
      logic en;
      logic first_in_row;
      logic first_in_col;
   } msp_upd_type;

endpackage

[rtl/core/msp_if.sv]
// Channel interfaces of the matrix saddle point search block.
// Depends on msp_pkg for the fixed field widths.
interface msp_req_if #(parameter int DATA_WIDTH = 16);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] element;

   modport source (output valid, output element, input ready);
   modport sink   (input valid, input element, output ready);
endinterface

interface msp_rsp_if #(parameter int DATA_WIDTH = 16);
   logic                                valid;
   logic                                ready;
   logic                                found;
   logic [msp_pkg::INDEX_WIDTH-1:0]     row_index;
   logic [msp_pkg::INDEX_WIDTH-1:0]     col_index;
   logic signed [DATA_WIDTH-1:0]        point_value;
   logic                                last_result;

   modport source (output valid, output found, output row_index, output col_index,
                   output point_value, output last_result, input ready);
   modport sink   (input valid, input found, input row_index, input col_index,
                   input point_value, input last_result, output ready);
endinterface

interface msp_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [msp_pkg::CSR_INDEX_WIDTH-1:0]  index;
   logic [msp_pkg::COUNT_WIDTH-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/msp_elem_ram.sv]
// Element store: one write port, one read port with registered read data.
// No package dependencies.
module msp_elem_ram #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 16,
   parameter int ADDR_WIDTH = 6
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ADDR_WIDTH-1:0]        wr_addr,
   input  logic signed [DATA_WIDTH-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [ADDR_WIDTH-1:0]        rd_addr,
   output logic signed [DATA_WIDTH-1:0] rd_data
);

   logic signed [DATA_WIDTH-1:0] store_ff [DEPTH];
   logic signed [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/msp_extremes.sv]
// Running row maxima and column minima, one register file of each.
// Depends on msp_pkg for the update struct.
module msp_extremes #(
   parameter int MAX_ROWS   = 8,
   parameter int MAX_COLS   = 8,
   parameter int DATA_WIDTH = 16,
   parameter int ROW_WIDTH  = 3,
   parameter int COL_WIDTH  = 3
) (
   input  logic                         clock,
   input  msp_pkg::msp_upd_type         upd,
   input  logic [ROW_WIDTH-1:0]         row,
   input  logic [COL_WIDTH-1:0]         col,
   input  logic signed [DATA_WIDTH-1:0] value,
   output logic signed [DATA_WIDTH-1:0] row_max,
   output logic signed [DATA_WIDTH-1:0] col_min
);

   logic signed [DATA_WIDTH-1:0] row_max_ff [MAX_ROWS];
   logic signed [DATA_WIDTH-1:0] col_min_ff [MAX_COLS];

   assign row_max = row_max_ff[row];
   assign col_min = col_min_ff[col];

   always_ff @(posedge clock) begin
      if (upd.en) begin
         // first element of a row or column seeds its extreme
         if (upd.first_in_row || (value > row_max)) begin
            row_max_ff[row] <= value;
         end
         if (upd.first_in_col || (value < col_min)) begin
            col_min_ff[col] <= value;
         end
      end
   end

endmodule

[rtl/core/matrix_saddle_point_search.sv]
// Top level of the matrix saddle point search: load control, scan and result stage.
// Depends on msp_pkg, the msp interfaces, msp_elem_ram and msp_extremes.
//
//  channel   dir  interface    word
//  req_chan  in   msp_req_if   one matrix element, row-major
//  rsp_chan  out  msp_rsp_if   one saddle point or not-found, last marked
//  csr_chan  in   msp_csr_if   register index and count value
//
// Elements load at one per cycle in the load state; the input is held off until
// the run closes. After the final element the store is read once per cycle over
// rows*cols entries while the result side keeps up; the read data register and the
// scan stage precede the last word. Reads go through the store's single read port.
// Reset is synchronous and clears control state only; no clearing pass.
// A full, untaken result register freezes the scan until the word is taken.
module matrix_saddle_point_search #(
   parameter int MAX_ROWS   = 8,
   parameter int MAX_COLS   = 8,
   parameter int DATA_WIDTH = 16
) (
   input logic       clock,
   input logic       reset,
   msp_req_if.sink   req_chan,
   msp_rsp_if.source rsp_chan,
   msp_csr_if.sink   csr_chan
);

   localparam int DEPTH      = MAX_ROWS * MAX_COLS;
   localparam int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ROW_WIDTH  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_WIDTH  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RCNT_WIDTH = $clog2(MAX_ROWS + 1);
   localparam int CCNT_WIDTH = $clog2(MAX_COLS + 1);
   localparam int IW         = msp_pkg::INDEX_WIDTH;
   localparam int CW         = msp_pkg::COUNT_WIDTH;

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [CW-1:0]        row_cnt_ff, row_cnt_in;
   logic [CW-1:0]        col_cnt_ff, col_cnt_in;
   logic [ROW_WIDTH-1:0] load_row_ff, load_row_in;
   logic [COL_WIDTH-1:0] load_col_ff, load_col_in;
   logic [ROW_WIDTH-1:0] scan_row_ff, scan_row_in;
   logic [COL_WIDTH-1:0] scan_col_ff, scan_col_in;
   logic                 p1_valid_ff, p1_valid_in;
   logic [ROW_WIDTH-1:0] p1_row_ff, p1_row_in;
   logic [COL_WIDTH-1:0] p1_col_ff, p1_col_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [ROW_WIDTH-1:0] pend_row_ff, pend_row_in;
   logic [COL_WIDTH-1:0] pend_col_ff, pend_col_in;
   logic signed [DATA_WIDTH-1:0] pend_value_ff, pend_value_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [IW-1:0]        rsp_row_ff, rsp_row_in;
   logic [IW-1:0]        rsp_col_ff, rsp_col_in;
   logic signed [DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [RCNT_WIDTH-1:0] rows_eff;
   logic [CCNT_WIDTH-1:0] cols_eff;
   logic                  req_fire, csr_fire, adv, issue;
   logic                  load_row_end, load_col_end, scan_row_end, scan_col_end;
   logic                  saddle;
   logic [ADDR_WIDTH-1:0] wr_addr, rd_addr;
   logic signed [DATA_WIDTH-1:0] rd_data, row_max, col_min;
   logic [ROW_WIDTH-1:0]  ext_row;
   logic [COL_WIDTH-1:0]  ext_col;
   msp_pkg::msp_upd_type  upd;

   // A count of zero means one; above the maximum means the maximum.
   always_comb begin
      if (row_cnt_ff == '0) begin
         rows_eff = RCNT_WIDTH'(1);
      end else if (int'(row_cnt_ff) > MAX_ROWS) begin
         rows_eff = RCNT_WIDTH'(MAX_ROWS);
      end else begin
         rows_eff = RCNT_WIDTH'(row_cnt_ff);
      end
      if (col_cnt_ff == '0) begin
         cols_eff = CCNT_WIDTH'(1);
      end else if (int'(col_cnt_ff) > MAX_COLS) begin
         cols_eff = CCNT_WIDTH'(MAX_COLS);
      end else begin
         cols_eff = CCNT_WIDTH'(col_cnt_ff);
      end
   end

   assign req_chan.ready = (state_ff == ST_LOAD);
   assign csr_chan.ready = 1'b1;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_fire       = csr_chan.valid;
   assign adv            = !rsp_valid_ff || rsp_chan.ready;
   assign issue          = (state_ff == ST_SCAN) && adv;

   assign load_row_end = (int'(load_row_ff) + 1) == int'(rows_eff);
   assign load_col_end = (int'(load_col_ff) + 1) == int'(cols_eff);
   assign scan_row_end = (int'(scan_row_ff) + 1) == int'(rows_eff);
   assign scan_col_end = (int'(scan_col_ff) + 1) == int'(cols_eff);

   assign wr_addr = ADDR_WIDTH'(int'(load_row_ff) * MAX_COLS + int'(load_col_ff));
   assign rd_addr = ADDR_WIDTH'(int'(scan_row_ff) * MAX_COLS + int'(scan_col_ff));

   assign ext_row = (state_ff == ST_LOAD) ? load_row_ff : p1_row_ff;
   assign ext_col = (state_ff == ST_LOAD) ? load_col_ff : p1_col_ff;

   assign upd.en           = req_fire;
   assign upd.first_in_row = (load_col_ff == '0);
   assign upd.first_in_col = (load_row_ff == '0);

   msp_elem_ram #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (wr_addr),
      .wr_data (req_chan.element),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   msp_extremes #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .DATA_WIDTH (DATA_WIDTH),
      .ROW_WIDTH  (ROW_WIDTH),
      .COL_WIDTH  (COL_WIDTH)
   ) u_extremes (
      .clock   (clock),
      .upd     (upd),
      .row     (ext_row),
      .col     (ext_col),
      .value   (req_chan.element),
      .row_max (row_max),
      .col_min (col_min)
   );

   assign saddle = p1_valid_ff && (rd_data == row_max) && (rd_data == col_min);

   always_comb begin
      state_in      = state_ff;
      row_cnt_in    = row_cnt_ff;
      col_cnt_in    = col_cnt_ff;
      load_row_in   = load_row_ff;
      load_col_in   = load_col_ff;
      scan_row_in   = scan_row_ff;
      scan_col_in   = scan_col_ff;
      p1_valid_in   = p1_valid_ff;
      p1_row_in     = p1_row_ff;
      p1_col_in     = p1_col_ff;
      pend_valid_in = pend_valid_ff;
      pend_row_in   = pend_row_ff;
      pend_col_in   = pend_col_ff;
      pend_value_in = pend_value_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;

      // the result register empties when taken; a new word may refill it below
      if (adv) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff) inside
         ST_LOAD: begin
            if (req_fire) begin
               if (!load_col_end) begin
                  load_col_in = load_col_ff + 1'b1;
               end else begin
                  load_col_in = '0;
                  if (!load_row_end) begin
                     load_row_in = load_row_ff + 1'b1;
                  end else begin
                     load_row_in   = '0;
                     scan_row_in   = '0;
                     scan_col_in   = '0;
                     pend_valid_in = 1'b0;
                     state_in      = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN, ST_FLUSH: begin
            if (adv) begin
               p1_valid_in = issue;
               p1_row_in   = scan_row_ff;
               p1_col_in   = scan_col_ff;
               if (issue) begin
                  if (!scan_col_end) begin
                     scan_col_in = scan_col_ff + 1'b1;
                  end else begin
                     scan_col_in = '0;
                     if (!scan_row_end) begin
                        scan_row_in = scan_row_ff + 1'b1;
                     end else begin
                        state_in = ST_FLUSH;
                     end
                  end
               end
               if (saddle) begin
                  // push the held point out; keep the new one back for the last mark
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_found_in = 1'b1;
                     rsp_row_in   = IW'(pend_row_ff);
                     rsp_col_in   = IW'(pend_col_ff);
                     rsp_value_in = pend_value_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_row_in   = p1_row_ff;
                  pend_col_in   = p1_col_ff;
                  pend_value_in = rd_data;
               end else if ((state_ff == ST_FLUSH) && !p1_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_found_in  = pend_valid_ff;
                  rsp_row_in    = pend_valid_ff ? IW'(pend_row_ff) : '0;
                  rsp_col_in    = pend_valid_ff ? IW'(pend_col_ff) : '0;
                  rsp_value_in  = pend_valid_ff ? pend_value_ff : '0;
                  rsp_last_in   = 1'b1;
                  pend_valid_in = 1'b0;
                  state_in      = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      if (csr_fire) begin
         unique case (csr_chan.index)
            msp_pkg::REG_ROW_COUNT: begin
               row_cnt_in  = csr_chan.data;
               load_row_in = '0;
               load_col_in = '0;
            end
            msp_pkg::REG_COL_COUNT: begin
               col_cnt_in  = csr_chan.data;
               load_row_in = '0;
               load_col_in = '0;
            end
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         row_cnt_ff    <= msp_pkg::ROW_COUNT_RESET;
         col_cnt_ff    <= msp_pkg::COL_COUNT_RESET;
         load_row_ff   <= '0;
         load_col_ff   <= '0;
         scan_row_ff   <= '0;
         scan_col_ff   <= '0;
         p1_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_cnt_ff    <= row_cnt_in;
         col_cnt_ff    <= col_cnt_in;
         load_row_ff   <= load_row_in;
         load_col_ff   <= load_col_in;
         scan_row_ff   <= scan_row_in;
         scan_col_ff   <= scan_col_in;
         p1_valid_ff   <= p1_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_row_ff     <= p1_row_in;
      p1_col_ff     <= p1_col_in;
      pend_row_ff   <= pend_row_in;
      pend_col_ff   <= pend_col_in;
      pend_value_ff <= pend_value_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.row_index   = rsp_row_ff;
   assign rsp_chan.col_index   = rsp_col_ff;
   assign rsp_chan.point_value = rsp_value_ff;
   assign rsp_chan.last_result = rsp_last_ff;

   a_notfound_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> rsp_last_ff)
      else $error("not-found word without last mark");

   a_no_scan_in_load : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (!p1_valid_ff && !pend_valid_ff))
      else $error("scan stage busy while loading");

   a_load_col_range : assert property (@(posedge clock) disable iff (reset)
      int'(load_col_ff) < int'(cols_eff))
      else $error("load column out of range");

   a_flush_returns : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FLUSH) && adv && !p1_valid_ff) |=>
         ((state_ff == ST_LOAD) && rsp_valid_ff && rsp_last_ff))
      else $error("run did not close with a last word");

endmodule

[bench/tb_matrix_saddle_point_search.sv]
// Self-checking testbench for matrix_saddle_point_search: a directed table of matrices and
// register writes, then random matrices, checked against a saddle point predictor.
// Depends on msp_pkg, the msp channel interfaces and the block itself.
module tb_matrix_saddle_point_search;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_ROWS        = 8;
   localparam int MAX_COLS        = 8;
   localparam int DATA_WIDTH      = 16;
   localparam int CSR_INDEX_WIDTH = msp_pkg::CSR_INDEX_WIDTH;
   localparam int COUNT_WIDTH     = msp_pkg::COUNT_WIDTH;
   localparam int INDEX_WIDTH     = msp_pkg::INDEX_WIDTH;
   localparam int IDLE_PCT        = 33;
   localparam int HOLD_LEN        = 400;
   localparam int SCAN_TAIL       = MAX_ROWS * MAX_COLS + 16;
   localparam int ITEM_TARGET     = 430;
   localparam int MAX_REPORTS     = 10;
   localparam int SCRIPT_LEN      = 29;

   // Index outside the register list; writes to it are dropped.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPARE = 4'd9;

   typedef struct packed {
      logic                         found;
      logic [INDEX_WIDTH-1:0]       row_index;
      logic [INDEX_WIDTH-1:0]       col_index;
      logic signed [DATA_WIDTH-1:0] point_value;
      logic                         last_result;
   } saddle_word_type;

   typedef enum logic {STEP_WRITE, STEP_ELEMENT} step_kind_type;

   typedef struct packed {
      step_kind_type                kind;
      logic [CSR_INDEX_WIDTH-1:0]   index;
      logic [COUNT_WIDTH-1:0]       data;
      logic signed [DATA_WIDTH-1:0] element;
      logic                         typed;
      saddle_word_type              word;
   } step_type;

   localparam saddle_word_type NO_WORD = '0;

   localparam logic signed [DATA_WIDTH-1:0] CORNER_VALUES [4] =
      '{16'sh8000, 16'shFFFF, 16'sh0000, 16'sh7FFF};

   // Directed part: a load cut short by a write, a single row under the reset column
   // count, 1x1 extremes, zero counts, a matrix with no saddle point, an ignored
   // register write in mid-load and a matrix of equal values.
   localparam step_type SCRIPT [SCRIPT_LEN] = '{
      '{STEP_ELEMENT, msp_pkg::REG_ROW_COUNT, 4'd0, 16'sd100,    1'b0, NO_WORD},
      '{STEP_ELEMENT, msp_pkg::REG_ROW_COUNT, 4'd0, -16'sd7,     1'b0, NO_WORD},
      '{STEP_ELEMENT, msp_pkg::REG_ROW_COUNT, 4'd0, 16'sd3,      1'b0, NO_WORD},
      '{STEP_WRITE,   msp_pkg::REG_ROW_COUNT, 4'd1, 16'sd0,      1'b0, NO_WORD},
      '{STEP_ELEMENT, msp_pkg::REG_ROW_COUNT, 4'd0, 16'sd5,      1'b0, NO_WORD},
      '{STEP_ELEMENT, msp_pkg::REG_ROW_COUNT, 4'd0, 16'sh8000,   1'b0, NO_WORD},
      '{STEP_ELEMENT, msp_pkg::REG_ROW_COUNT, 4'd0, 16'sh7FFF,   1'b0, NO_WORD},
      '{STEP_ELEMENT, msp_pkg::REG_ROW_COUNT, 4'd0, 16'sd0,      1'b0, NO_WORD},
      '{STEP_ELEMENT, msp_pkg::REG_ROW_COUNT, 4'd0, 16'sh7FFF,   1'b0, NO_WORD},
      '{STEP_ELEMENT, msp_pkg::REG_ROW_COUNT, 4'd0, 16'sd1,      1'b0, NO_WORD},
      '{STEP_ELEMENT, msp_pkg::REG_ROW_COUNT, 4'd0, 16'shFFFF,   1'b0, NO_WORD},
      '{STEP_ELEMENT, msp_pkg::REG_ROW_COUNT, 4'd0, 16'sd2,      1'b0, NO_WORD},
      '{STEP_WRITE,   msp_pkg::REG_COL_COUNT, 4'd1, 16'sd0,      1'b0, NO_WORD},
      '{STEP_ELEMENT, msp_pkg::REG_ROW_COUNT, 4'd0, 16'sh7FFF,   1'b1,
        '{1'b1, 3'd0, 3'd0, 16'sh7FFF, 1'b1}},
      '{STEP_ELEMENT, msp_pkg::REG_ROW_COUNT, 4'd0, 16'sh8000,   1'b1,
        '{1'b1, 3'd0, 3'd0, 16'sh8000, 1'b1}},
      '{STEP_WRITE,   msp_pkg::REG_ROW_COUNT, 4'd0, 16'sd0,      1'b0, NO_WORD},
      '{STEP_WRITE,   msp_pkg::REG_COL_COUNT, 4'd0, 16'sd0,      1'b0, NO_WORD},
      '{STEP_ELEMENT, msp_pkg::REG_ROW_COUNT, 4'd0, 16'shFFFF,   1'b1,
        '{1'b1, 3'd0, 3'd0, 16'shFFFF, 1'b1}},
      '{STEP_WRITE,   msp_pkg::REG_ROW_COUNT, 4'd2, 16'sd0,      1'b0, NO_WORD},
      '{STEP_WRITE,   msp_pkg::REG_COL_COUNT, 4'd2, 16'sd0,      1'b0, NO_WORD},
      '{STEP_ELEMENT, msp_pkg::REG_ROW_COUNT, 4'd0, 16'sd1,      1'b0, NO_WORD},
      '{STEP_ELEMENT, msp_pkg::REG_ROW_COUNT, 4'd0, 16'sd2,      1'b0, NO_WORD},
      '{STEP_ELEMENT, msp_pkg::REG_ROW_COUNT, 4'd0, 16'sd3,      1'b0, NO_WORD},
      '{STEP_ELEMENT, msp_pkg::REG_ROW_COUNT, 4'd0, 16'sd0,      1'b1,
        '{1'b0, 3'd0, 3'd0, 16'sd0, 1'b1}},
      '{STEP_ELEMENT, msp_pkg::REG_ROW_COUNT, 4'd0, 16'sd7,      1'b0, NO_WORD},
      '{STEP_ELEMENT, msp_pkg::REG_ROW_COUNT, 4'd0, 16'sd7,      1'b0, NO_WORD},
      '{STEP_WRITE,   REG_SPARE,              4'd5, 16'sd0,      1'b0, NO_WORD},
      '{STEP_ELEMENT, msp_pkg::REG_ROW_COUNT, 4'd0, 16'sd7,      1'b0, NO_WORD},
      '{STEP_ELEMENT, msp_pkg::REG_ROW_COUNT, 4'd0, 16'sd7,      1'b0, NO_WORD}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   msp_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_chan ();
   msp_rsp_if #(.DATA_WIDTH(DATA_WIDTH)) rsp_chan ();
   msp_csr_if                            csr_chan ();

   matrix_saddle_point_search #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .DATA_WIDTH (DATA_WIDTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #5 clock = ~clock;

   // Predictor state: counts as written, load position and the stored matrix.
   logic [COUNT_WIDTH-1:0]       row_cnt = msp_pkg::ROW_COUNT_RESET;
   logic [COUNT_WIDTH-1:0]       col_cnt = msp_pkg::COL_COUNT_RESET;
   int                           ld_row  = 0;
   int                           ld_col  = 0;
   logic signed [DATA_WIDTH-1:0] cell_store [MAX_ROWS*MAX_COLS];
   logic signed [DATA_WIDTH-1:0] row_max    [MAX_ROWS];
   logic signed [DATA_WIDTH-1:0] col_min    [MAX_COLS];

   saddle_word_type saddle_due [$];
   int           failures    = 0;
   int           words_seen  = 0;
   int           items_sent  = 0;
   logic         steady      = 1'b0;
   int           hold_asked  = 0;
   int           hold_served = 0;
   int           hold_left   = 0;

   function automatic int span(input logic [COUNT_WIDTH-1:0] cnt, input int limit);
      if (cnt == 0) return 1;
      if (cnt > limit) return limit;
      return int'(cnt);
   endfunction

   function automatic void set_count(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                     input logic [COUNT_WIDTH-1:0] val);
      if (idx == msp_pkg::REG_ROW_COUNT) row_cnt = val;
      else if (idx == msp_pkg::REG_COL_COUNT) col_cnt = val;
      else return;
      ld_row = 0;
      ld_col = 0;
   endfunction

   // Load one element; on the final element scan for saddle points.
   function automatic void load_element(input logic signed [DATA_WIDTH-1:0] v,
                                        output saddle_word_type found_words [$]);
      int              nr;
      int              nc;
      int              r;
      int              c;
      saddle_word_type w;
      nr = span(row_cnt, MAX_ROWS);
      nc = span(col_cnt, MAX_COLS);
      found_words = {};
      if (ld_row >= nr || ld_col >= nc) begin
         ld_row = 0;
         ld_col = 0;
      end
      r = ld_row;
      c = ld_col;
      cell_store[r*MAX_COLS + c] = v;
      if (c == 0 || v > row_max[r]) row_max[r] = v;
      if (r == 0 || v < col_min[c]) col_min[c] = v;
      if (c + 1 < nc) begin
         ld_col = c + 1;
         return;
      end
      ld_col = 0;
      if (r + 1 < nr) begin
         ld_row = r + 1;
         return;
      end
      ld_row = 0;
      for (r = 0; r < nr; r++) begin
         for (c = 0; c < nc; c++) begin
            if (cell_store[r*MAX_COLS + c] == row_max[r] &&
                cell_store[r*MAX_COLS + c] == col_min[c]) begin
               w.found       = 1'b1;
               w.row_index   = INDEX_WIDTH'(r);
               w.col_index   = INDEX_WIDTH'(c);
               w.point_value = cell_store[r*MAX_COLS + c];
               w.last_result = 1'b0;
               found_words.push_back(w);
            end
         end
      end
      if (found_words.size() == 0) begin
         w = NO_WORD;
         w.last_result = 1'b1;
         found_words.push_back(w);
      end else begin
         found_words[found_words.size()-1].last_result = 1'b1;
      end
   endfunction

   function automatic void check_word();
      saddle_word_type want;
      words_seen++;
      if (saddle_due.size() == 0) begin
         failures++;
         if (failures <= MAX_REPORTS)
            $display("unexpected word: found %0b row %0d col %0d value %0d last %0b",
                     rsp_chan.found, rsp_chan.row_index, rsp_chan.col_index,
                     rsp_chan.point_value, rsp_chan.last_result);
         return;
      end
      want = saddle_due.pop_front();
      if (rsp_chan.found !== want.found || rsp_chan.row_index !== want.row_index ||
          rsp_chan.col_index !== want.col_index ||
          rsp_chan.point_value !== want.point_value ||
          rsp_chan.last_result !== want.last_result) begin
         failures++;
         if (failures <= MAX_REPORTS)
            $display("word %0d: expected %0b/%0d/%0d/%0d/%0b, got %0b/%0d/%0d/%0d/%0b",
                     words_seen, want.found, want.row_index, want.col_index,
                     want.point_value, want.last_result, rsp_chan.found,
                     rsp_chan.row_index, rsp_chan.col_index, rsp_chan.point_value,
                     rsp_chan.last_result);
      end
   endfunction

   // Result side: check taken words, then pick the next ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) check_word();
         if (hold_asked != hold_served) begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_LEN;
            rsp_chan.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   task automatic push_element(input logic signed [DATA_WIDTH-1:0] v, input logic typed,
                               input saddle_word_type word);
      saddle_word_type due [$];
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.element <= v;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      load_element(v, due);
      if (typed) begin
         if (due.size() != 0) saddle_due.push_back(word);
      end else begin
         foreach (due[i]) saddle_due.push_back(due[i]);
      end
      items_sent++;
   endtask

   // Hold until every expected word is in, then let any scan in flight settle.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (saddle_due.size() != 0) @(posedge clock);
      repeat (SCAN_TAIL) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [COUNT_WIDTH-1:0] val);
      wait_idle();
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      csr_chan.valid <= 1'b0;
      set_count(idx, val);
   endtask

   initial begin
      int                           mat_no;
      int                           kind;
      int                           nr;
      int                           nc;
      int                           r0;
      int                           c0;
      int                           s;
      int                           cut;
      int                           pick;
      logic [CSR_INDEX_WIDTH-1:0]   idx;
      logic [COUNT_WIDTH-1:0]       val;
      logic signed [DATA_WIDTH-1:0] cells [MAX_ROWS*MAX_COLS];

      req_chan.valid   <= 1'b0;
      req_chan.element <= '0;
      csr_chan.valid   <= 1'b0;
      csr_chan.index   <= '0;
      csr_chan.data    <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (SCRIPT[i]) begin
         if (SCRIPT[i].kind == STEP_WRITE) write_reg(SCRIPT[i].index, SCRIPT[i].data);
         else push_element(SCRIPT[i].element, SCRIPT[i].typed, SCRIPT[i].word);
      end

      mat_no = 0;
      while (items_sent < ITEM_TARGET) begin
         if (mat_no == 6) hold_asked <= hold_asked + 1;
         if (mat_no == 12) wait_idle();
         if (mat_no == 20) steady <= 1'b1;
         if (mat_no == 30) steady <= 1'b0;

         // Keep the hold-off matrices back to back so the block backs up.
         if ((mat_no < 6 || mat_no >= 10) && $urandom_range(99) < 25) begin
            pick = $urandom_range(99);
            if (pick < 85)
               idx = CSR_INDEX_WIDTH'($urandom_range(msp_pkg::REG_COL_COUNT,
                                                     msp_pkg::REG_ROW_COUNT));
            else
               idx = CSR_INDEX_WIDTH'($urandom_range(15, msp_pkg::REG_COL_COUNT + 1));
            pick = $urandom_range(99);
            if (pick < 70)      val = COUNT_WIDTH'($urandom_range(4, 1));
            else if (pick < 85) val = COUNT_WIDTH'($urandom_range(8, 5));
            else                val = COUNT_WIDTH'($urandom_range(15, 0));
            write_reg(idx, val);
         end

         nr   = span(row_cnt, MAX_ROWS);
         nc   = span(col_cnt, MAX_COLS);
         kind = $urandom_range(99);
         r0   = $urandom_range(nr - 1);
         c0   = $urandom_range(nc - 1);
         s    = int'($urandom_range(32000)) - 16000;
         for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
               if (kind < 10 || kind >= 90)
                  cells[r*nc + c] = DATA_WIDTH'($urandom);
               else if (kind < 25)
                  cells[r*nc + c] = ($urandom_range(1) == 0) ? CORNER_VALUES[$urandom_range(3)]
                                                            : DATA_WIDTH'($urandom);
               else if (kind < 40)
                  cells[r*nc + c] = DATA_WIDTH'(s + int'($urandom_range(3)));
               else if (kind < 50)
                  cells[r*nc + c] = DATA_WIDTH'(s);
               else if (r == r0 && c == c0)
                  cells[r*nc + c] = DATA_WIDTH'(s);
               else if (r == r0)
                  cells[r*nc + c] = DATA_WIDTH'(s - int'($urandom_range(16000)));
               else if (c == c0)
                  cells[r*nc + c] = DATA_WIDTH'(s + int'($urandom_range(16000)));
               else
                  cells[r*nc + c] = DATA_WIDTH'($urandom);
            end
         end

         if (kind >= 90 && nr * nc > 1) begin
            // Broken load: drop part of a matrix with a count write.
            cut = $urandom_range(nr * nc - 1, 1);
            for (int k = 0; k < cut; k++) push_element(cells[k], 1'b0, NO_WORD);
            idx = CSR_INDEX_WIDTH'($urandom_range(msp_pkg::REG_COL_COUNT,
                                                  msp_pkg::REG_ROW_COUNT));
            write_reg(idx, COUNT_WIDTH'($urandom_range(MAX_ROWS, 1)));
         end else begin
            for (int k = 0; k < nr * nc; k++) push_element(cells[k], 1'b0, NO_WORD);
         end
         mat_no++;
      end

      wait_idle();
      if (failures == 0 && saddle_due.size() == 0) begin
         $display("tb_matrix_saddle_point_search passed");
      end else begin
         $display("tb_matrix_saddle_point_search failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb_matrix_saddle_point_search failed");
      $finish;
   end

endmodule

[sim.f]
rtl/core/msp_pkg.sv
rtl/core/msp_if.sv
rtl/core/msp_elem_ram.sv
rtl/core/msp_extremes.sv
rtl/core/matrix_saddle_point_search.sv
bench/tb_matrix_saddle_point_search.sv
